FILE: src/dq_pkg.sv
// Shared types and codes for the double-ended queue.
`timescale 1ns / 1ps
package dq_pkg;

   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      FN_PUSH_FRONT = 3'd0,
      FN_PUSH_BACK  = 3'd1,
      FN_DUMP       = 3'd2,
      FN_POP_FRONT  = 3'd3,
      FN_POP_BACK   = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DUMP_RD
   } state_type;

   // One result on its way from the sequencer to the output register.
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] data;
      status_type               status;
      logic                     last;
   } result_type;

endpackage

FILE: src/double_ended_queue.sv
// Top level of the double-ended queue: sequencer, slot memory, output register.
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   req_func[2:0], req_value[31:0]
//  rsp      out        rsp_valid/rsp_stall   rsp_data[31:0], rsp_status[1:0], rsp_last
//
// One request is in the sequencer at a time: req_stall stays high until it is done.
// The sequencer takes the request and issues its slot read, then executes it once the
// slot memory's registered read data is in; a dump reads and executes each held value.
// Reset clears the head index, fill count and sequencer; slot contents are
// undefined until written and need no clearing pass.
// rsp_stall holds a result in the output register; the sequencer waits for it.
`timescale 1ns / 1ps
module double_ended_queue #(
   parameter int CAPACITY = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [2:0]                       req_func,
   input  logic signed [dq_pkg::DATA_W-1:0] req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [dq_pkg::DATA_W-1:0] rsp_data,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_last
);
   import dq_pkg::*;

   // ring index and fill count widths
   localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   result_type               result;
   logic                     out_free;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic signed [DATA_W-1:0] wr_data;
   logic                     rd_en;
   logic [AW-1:0]            rd_addr;
   logic signed [DATA_W-1:0] rd_data;

   // output register: one result parked here while the consumer stalls
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff;
   status_type               rsp_status_ff;
   logic                     rsp_last_ff;

   // the register can take a new result if empty or emptied at this edge
   assign out_free = !rsp_valid_ff || !rsp_stall;

   dq_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_value (req_value),
      .req_stall (req_stall),
      .out_free  (out_free),
      .result    (result),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   dq_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_data_ff   <= result.data;
         rsp_status_ff <= result.status;
         rsp_last_ff   <= result.last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

FILE: src/dq_ram.sv
// Slot memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module dq_ram #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic signed [dq_pkg::DATA_W-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   output logic signed [dq_pkg::DATA_W-1:0] rd_data
);
   import dq_pkg::*;

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/dq_ctrl.sv
// Sequencer: ring pointers, operation decode and slot memory accesses.
`timescale 1ns / 1ps
module dq_ctrl #(
   parameter int CAPACITY = 32,
   parameter int AW       = 5,
   parameter int CW       = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic [2:0]                       req_func,
   input  logic signed [dq_pkg::DATA_W-1:0] req_value,
   output logic                             req_stall,
   input  logic                             out_free,
   output dq_pkg::result_type               result,
   output logic                             wr_en,
   output logic [AW-1:0]                    wr_addr,
   output logic signed [dq_pkg::DATA_W-1:0] wr_data,
   output logic                             rd_en,
   output logic [AW-1:0]                    rd_addr,
   input  logic signed [dq_pkg::DATA_W-1:0] rd_data
);
   import dq_pkg::*;

   localparam logic [AW:0]   CAP_SUM = (AW+1)'(CAPACITY);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
   localparam logic [AW-1:0] LAST_IX = AW'(CAPACITY - 1);

   state_type                state_ff, state_in;
   func_type                 func_ff, func_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [AW-1:0]            head_ff, head_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            idx_ff, idx_in;

   logic          accept;
   logic          empty;
   logic          full;
   logic          dump_last;
   logic [CW-1:0] count_m1;

   // (base + off) mod CAPACITY, both operands below CAPACITY
   function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= CAP_SUM) begin
         sum = sum - CAP_SUM;
      end
      return sum[AW-1:0];
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CAP_CNT);
   assign count_m1  = count_ff - CW'(1);
   assign dump_last = ((CW'(idx_ff) + CW'(1)) == count_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (func_ff != FN_PUSH_FRONT && func_ff != FN_PUSH_BACK &&
                func_ff != FN_DUMP && func_ff != FN_POP_FRONT &&
                func_ff != FN_POP_BACK) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               if (func_ff == FN_DUMP && !empty && !dump_last) begin
                  state_in = S_DUMP_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_DUMP_RD: begin
            state_in = S_EXEC;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      func_in  = func_ff;
      value_in = value_ff;
      head_in  = head_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      wr_en    = 1'b0;
      wr_addr  = head_ff;
      wr_data  = value_ff;
      rd_en    = 1'b0;
      rd_addr  = head_ff;
      result   = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in  = func_type'(req_func);
               value_in = req_value;
               idx_in   = '0;
               // read the slot a pop or dump needs right away
               if (func_type'(req_func) == FN_POP_BACK) begin
                  rd_en   = 1'b1;
                  rd_addr = ring_pos(head_ff, count_m1[AW-1:0]);
               end else if (func_type'(req_func) == FN_POP_FRONT ||
                            func_type'(req_func) == FN_DUMP) begin
                  rd_en   = 1'b1;
                  rd_addr = head_ff;
               end
            end
         end
         S_EXEC: begin
            case (func_ff)
               FN_PUSH_FRONT, FN_PUSH_BACK: begin
                  if (out_free) begin
                     result.valid = 1'b1;
                     result.last  = 1'b1;
                     if (full) begin
                        result.status = ST_FULL;
                     end else begin
                        result.status = ST_OK;
                        wr_en         = 1'b1;
                        count_in      = count_ff + CW'(1);
                        if (func_ff == FN_PUSH_FRONT) begin
                           head_in = (head_ff == '0) ? LAST_IX : head_ff - AW'(1);
                           wr_addr = head_in;
                        end else begin
                           wr_addr = ring_pos(head_ff, count_ff[AW-1:0]);
                        end
                     end
                  end
               end
               FN_POP_FRONT, FN_POP_BACK: begin
                  if (out_free) begin
                     result.valid = 1'b1;
                     result.last  = 1'b1;
                     if (empty) begin
                        result.status = ST_EMPTY;
                     end else begin
                        result.status = ST_OK;
                        result.data   = rd_data;
                        count_in      = count_m1;
                        if (func_ff == FN_POP_FRONT) begin
                           head_in = ring_pos(head_ff, AW'(1));
                        end
                     end
                  end
               end
               FN_DUMP: begin
                  if (out_free) begin
                     result.valid = 1'b1;
                     if (empty) begin
                        result.status = ST_EMPTY;
                        result.last   = 1'b1;
                     end else begin
                        result.status = ST_OK;
                        result.data   = rd_data;
                        result.last   = dump_last;
                        idx_in        = idx_ff + AW'(1);
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         S_DUMP_RD: begin
            rd_en   = 1'b1;
            rd_addr = ring_pos(head_ff, idx_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      value_ff <= value_in;
      idx_ff   <= idx_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("fill count above capacity");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, head_ff} < CAP_SUM)
      else $error("head index outside the ring");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> out_free)
      else $error("result emitted while output register occupied");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (wr_en && result.valid) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("accepted push did not grow the fill count");

endmodule
